/* design/bb_pkg.sv */
// Shared types, constants and arithmetic helpers for the 3x3 RGB box blur.
// No dependencies; imported by the interfaces, the top level and the checker.
package bb_pkg;

  // Field and register widths
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 3 * CH_W;
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned ROW_W      = FH_W + 1;
  localparam int unsigned SUM_W      = 12;   // 9 * 255 fits
  localparam int unsigned CNT_W      = 4;    // neighbour count, 1..9
  localparam int unsigned RECIP_W    = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Request kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Register reset values
  localparam logic [FW_W-1:0] RESET_FRAME_WIDTH  = 11'd1024;
  localparam logic [FH_W-1:0] RESET_FRAME_HEIGHT = 13'd1;

  typedef logic [PIX_W-1:0] pix_t;

  // Which window rows / columns lie inside the frame
  typedef struct packed {
    logic row_top;
    logic row_bot;
    logic col_left;
    logic col_right;
  } win_mask_t;

  // Control carried alongside a beat through the pipeline
  typedef struct packed {
    logic      emit;
    logic      last;
    win_mask_t mask;
  } stage_ctl_t;

  // ceil(2^16 / (2*count)); exact for every numerator the window can produce
  function automatic logic [RECIP_W-1:0] mean_recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10923;
      4'd4:    r = 16'd8192;
      4'd6:    r = 16'd5462;
      4'd9:    r = 16'd3641;
      default: r = '0;
    endcase
    return r;
  endfunction

  // floor((2*sum + cnt) / (2*cnt)) by reciprocal multiply
  function automatic logic [CH_W-1:0] rounded_mean(input logic [SUM_W-1:0] sum,
                                                   input logic [CNT_W-1:0] cnt);
    logic [SUM_W:0]           num;
    logic [SUM_W+RECIP_W:0]   prod;
    num  = {sum, 1'b0} + (SUM_W+1)'(cnt);
    prod = (SUM_W+RECIP_W+1)'(num) * (SUM_W+RECIP_W+1)'(mean_recip(cnt));
    return prod[RECIP_W +: CH_W];
  endfunction

endpackage

/* design/bb_if.sv */
// Valid/ready stream interfaces for the box blur pixel input and output.
// Depends on bb_pkg for field widths.
interface bb_pix_in_if import bb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, req_type, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, req_type, red_in, green_in, blue_in, output ready);
endinterface

interface bb_pix_out_if import bb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

/* design/bb_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-edge collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/box_blur_3x3_rgb.sv */
// Streaming 3x3 RGB box blur: top level. Depends on bb_pkg, bb_if and bb_ram.
// Throughput: one beat per cycle unless the output stalls; a flush beat arriving before
// the frame is complete is swallowed in its cycle. A result is formed through the line
// store read, window, sum and output registers from the beat that completes its window.
// That beat is the one frame_width+1 positions later in raster order.
// Reset: asynchronous, clears control, counters and window; line stores are not cleared.
module box_blur_3x3_rgb import bb_pkg::*; #(
  parameter int unsigned MAX_LINE_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bb_pix_in_if.sink             pix_i,
  bb_pix_out_if.source          pix_o
);

  localparam int unsigned COL_W = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int unsigned WID_W = $clog2(MAX_LINE_WIDTH + 1);

  // ---------------------------------------------------------------- config
  logic [FW_W-1:0]  frame_width_q;
  logic [FH_W-1:0]  frame_height_q;
  logic [WID_W-1:0] eff_w;
  logic [FH_W-1:0]  eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RESET_FRAME_WIDTH;
      frame_height_q <= RESET_FRAME_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp width to 1..MAX_LINE_WIDTH, height to at least 1
  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = WID_W'(1);
    end else if (32'(frame_width_q) > MAX_LINE_WIDTH) begin
      eff_w = WID_W'(MAX_LINE_WIDTH);
    end else begin
      eff_w = WID_W'(frame_width_q);
    end
  end

  assign eff_h = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;

  // ---------------------------------------------------------------- position counters
  logic [ROW_W-1:0] in_row_q, out_row_q;
  logic [COL_W-1:0] in_col_q, out_col_q;
  logic [WID_W-1:0] col_nx, out_col_nx;
  logic [ROW_W-1:0] out_row_nx;
  logic             col_wrap, out_col_end, out_row_end;
  logic             in_frame, emit, last;
  win_mask_t        mask;

  assign in_frame    = in_row_q < ROW_W'(eff_h);
  assign emit        = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
  assign col_nx      = WID_W'(in_col_q) + WID_W'(1);
  assign col_wrap    = col_nx >= eff_w;
  assign out_col_nx  = WID_W'(out_col_q) + WID_W'(1);
  assign out_col_end = out_col_nx >= eff_w;
  assign out_row_nx  = out_row_q + ROW_W'(1);
  assign out_row_end = out_row_nx >= ROW_W'(eff_h);
  assign last        = out_row_end && out_col_end;

  assign mask.row_top   = out_row_q != '0;
  assign mask.row_bot   = !out_row_end;
  assign mask.col_left  = out_col_q != '0;
  assign mask.col_right = !out_col_end;

  // ---------------------------------------------------------------- handshake
  logic a_valid_q, b_valid_q, c_valid_q, o_valid_q;
  logic a_ready, b_ready, c_ready, o_ready;
  logic a_fire, b_fire, c_fire;
  logic ignore, go;

  assign o_ready = !o_valid_q || pix_o.ready;
  assign c_ready = !c_valid_q || o_ready;
  assign c_fire  = c_valid_q && o_ready;
  assign b_ready = !b_valid_q || c_ready;
  assign b_fire  = b_valid_q && c_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign a_fire  = a_valid_q && b_ready;

  assign pix_i.ready = a_ready;

  // a flush while pixels are still due is dropped without effect
  assign ignore = (pix_i.req_type == REQ_FLUSH) && in_frame;
  assign go     = pix_i.valid && a_ready && !ignore;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (cfg_we_i) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (go) begin
      if (emit && last) begin
        // frame done, restart for the next one
        in_row_q  <= '0;
        in_col_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
      end else begin
        in_col_q <= col_wrap ? '0 : COL_W'(col_nx);
        if (col_wrap) begin
          in_row_q <= in_row_q + ROW_W'(1);
        end
        if (emit) begin
          out_col_q <= out_col_end ? '0 : COL_W'(out_col_nx);
          if (out_col_end) begin
            out_row_q <= out_row_nx;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage A: line store read
  logic             a_inframe_q;
  logic [COL_W-1:0] a_col_q;
  pix_t             a_bot_q;
  stage_ctl_t       a_ctl_q;
  logic             a_fwd_q;
  pix_t             a_fwd_top_q, a_fwd_mid_q;
  pix_t             upper_rdata, middle_rdata;
  pix_t             top_eff, mid_eff;
  logic             st_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= go;
    end
  end

  // forward the write of the beat ahead when it hits the column being read
  always_ff @(posedge clk_i) begin
    if (go) begin
      a_inframe_q  <= in_frame;
      a_col_q      <= in_col_q;
      a_bot_q      <= in_frame ? {pix_i.red_in, pix_i.green_in, pix_i.blue_in} : '0;
      a_ctl_q.emit <= emit;
      a_ctl_q.last <= last;
      a_ctl_q.mask <= mask;
      a_fwd_q      <= a_fire && a_inframe_q && (a_col_q == in_col_q);
      a_fwd_top_q  <= mid_eff;
      a_fwd_mid_q  <= a_bot_q;
    end
  end

  assign top_eff = a_fwd_q ? a_fwd_top_q : upper_rdata;
  assign mid_eff = a_fwd_q ? a_fwd_mid_q : middle_rdata;
  assign st_we   = a_fire && a_inframe_q;

  bb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (a_col_q),
    .wdata_i (mid_eff),
    .re_i    (go),
    .raddr_i (in_col_q),
    .rdata_o (upper_rdata)
  );

  bb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (a_col_q),
    .wdata_i (a_bot_q),
    .re_i    (go),
    .raddr_i (in_col_q),
    .rdata_o (middle_rdata)
  );

  // ---------------------------------------------------------------- stage B: 3x3 window
  // index = column*3 + row, column 0 oldest
  pix_t       win_q [9];
  stage_ctl_t b_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (a_fire) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= win_q[i+3];
      end
      win_q[6] <= top_eff;
      win_q[7] <= mid_eff;
      win_q[8] <= a_bot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_fire && a_ctl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_ctl_q <= a_ctl_q;
    end
  end

  // ---------------------------------------------------------------- stage C: masked sums
  logic [SUM_W-1:0] sum_d [3];
  logic [SUM_W-1:0] c_sum_q [3];
  logic [CNT_W-1:0] cnt_d, c_cnt_q;
  logic             c_last_q;
  logic [2:0]       row_v, col_v;
  logic [1:0]       n_rows, n_cols;

  assign row_v  = {b_ctl_q.mask.row_bot, 1'b1, b_ctl_q.mask.row_top};
  assign col_v  = {b_ctl_q.mask.col_right, 1'b1, b_ctl_q.mask.col_left};
  assign n_rows = 2'd1 + 2'(b_ctl_q.mask.row_top) + 2'(b_ctl_q.mask.row_bot);
  assign n_cols = 2'd1 + 2'(b_ctl_q.mask.col_left) + 2'(b_ctl_q.mask.col_right);
  assign cnt_d  = CNT_W'(n_rows) * CNT_W'(n_cols);

  // channel 0 red, 1 green, 2 blue
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (col_v[c] && row_v[r]) begin
            sum_d[ch] = sum_d[ch] + SUM_W'(win_q[c*3+r][CH_W*(2-ch) +: CH_W]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= b_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      c_sum_q  <= sum_d;
      c_cnt_q  <= cnt_d;
      c_last_q <= b_ctl_q.last;
    end
  end

  // ---------------------------------------------------------------- output register: divide
  logic [CH_W-1:0] o_red_q, o_green_q, o_blue_q;
  logic            o_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_ready) begin
      o_valid_q <= c_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_fire) begin
      o_red_q   <= rounded_mean(c_sum_q[0], c_cnt_q);
      o_green_q <= rounded_mean(c_sum_q[1], c_cnt_q);
      o_blue_q  <= rounded_mean(c_sum_q[2], c_cnt_q);
      o_end_q   <= c_last_q;
    end
  end

  assign pix_o.valid     = o_valid_q;
  assign pix_o.red_out   = o_red_q;
  assign pix_o.green_out = o_green_q;
  assign pix_o.blue_out  = o_blue_q;
  assign pix_o.frame_end = o_end_q;

endmodule

/* design/bb_checker.sv */
// Port-level checks for box_blur_3x3_rgb, attached by the bind at the end.
// Depends on bb_pkg for the result beat width.
module bb_checker import bb_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [PIX_W:0]      out_beat_i
);

  // a stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat withdrawn while stalled");

  // and keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_beat_i))
    else $error("result beat changed while stalled");

  // with the output register empty nothing can back up the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // no result straight out of reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("result beat valid on reset release");

endmodule

bind box_blur_3x3_rgb bb_checker u_bb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_beat_i  ({pix_o.red_out, pix_o.green_out, pix_o.blue_out, pix_o.frame_end})
);

/* sim/box_blur_checker.sv */
// Scoreboard for the 3x3 RGB box blur: predicts every output beat and compares it.
// Depends on bb_pkg and the stream interfaces in bb_if; watches the config port too.
`timescale 1ns / 1ps

module box_blur_checker import bb_pkg::*; #(
  parameter int unsigned LINE_DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bb_pix_in_if                  pix_i,
  bb_pix_out_if                 pix_o,
  output int                    fail_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } blur_px_t;

  // Shadow of the block: line stores, window, geometry and raster counters
  pix_t            upper_line  [LINE_DEPTH];
  pix_t            middle_line [LINE_DEPTH];
  pix_t            win [9];    // column*3 + row, column 0 oldest
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  int unsigned     in_row, in_col, out_row, out_col;

  blur_px_t blurred_q [$];
  blur_px_t got, want;
  int       err_cnt;

  function automatic int unsigned width_eff();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned height_eff();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  // Rounded mean of one colour over the in-frame part of the window
  function automatic logic [CH_W-1:0] window_mean(input int unsigned lsb,
                                                  input logic [2:0] rows_in,
                                                  input logic [2:0] cols_in);
    int unsigned total, cnt;
    int c, r;
    total = 0;
    cnt   = 0;
    for (c = 0; c < 3; c++)
      for (r = 0; r < 3; r++)
        if (cols_in[c] && rows_in[r]) begin
          total += (win[c*3+r] >> lsb) & 8'hFF;
          cnt++;
        end
    return CH_W'((2 * total + cnt) / (2 * cnt));
  endfunction

  task automatic restart_frame();
    in_row  = 0;
    in_col  = 0;
    out_row = 0;
    out_col = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
  endtask

  // One accepted input beat: update the shadow and queue any result it completes
  task automatic blur_beat(input logic kind, input pix_t colour);
    int unsigned w, h, col;
    pix_t        top_px, mid_px, bot_px;
    logic        in_frame, emit, last;
    logic [2:0]  rows_in, cols_in;
    blur_px_t    px;
    w        = width_eff();
    h        = height_eff();
    col      = (in_col < w) ? in_col : 0;
    in_frame = in_row < h;
    // a flush before the frame is complete is swallowed
    if (!(kind == REQ_FLUSH && in_frame)) begin
      top_px = upper_line[col];
      mid_px = middle_line[col];
      if (in_frame) begin
        bot_px           = colour;
        upper_line[col]  = mid_px;
        middle_line[col] = colour;
      end else begin
        bot_px = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = top_px;
      win[7] = mid_px;
      win[8] = bot_px;

      emit = (in_row >= 2) || (in_row == 1 && col >= 1);
      col++;
      if (col >= w) begin
        col = 0;
        in_row++;
      end
      in_col = col;

      if (emit) begin
        last    = (out_row + 1 >= h) && (out_col + 1 >= w);
        rows_in = {out_row + 1 < h, 1'b1, out_row != 0};
        cols_in = {out_col + 1 < w, 1'b1, out_col != 0};
        px.red       = window_mean(2 * CH_W, rows_in, cols_in);
        px.green     = window_mean(CH_W, rows_in, cols_in);
        px.blue      = window_mean(0, rows_in, cols_in);
        px.frame_end = last;
        blurred_q.push_back(px);
        if (last) begin
          restart_frame();
        end else begin
          out_col++;
          if (out_col >= w) begin
            out_col = 0;
            out_row++;
          end
        end
      end
    end
  endtask

  task automatic note_failure(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // Output beats are checked before the input beat of the same edge is predicted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      width_reg  = RESET_FRAME_WIDTH;
      height_reg = RESET_FRAME_HEIGHT;
      restart_frame();
      blurred_q.delete();
      err_cnt = 0;
    end else begin
      if (pix_o.valid && pix_o.ready) begin
        got = {pix_o.red_out, pix_o.green_out, pix_o.blue_out, pix_o.frame_end};
        if (blurred_q.size() == 0) begin
          note_failure($sformatf("%0t: output beat with nothing expected: r=%0d g=%0d b=%0d end=%0b",
                                 $realtime, got.red, got.green, got.blue, got.frame_end));
        end else begin
          want = blurred_q.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.frame_end !== want.frame_end)
            note_failure($sformatf(
              "%0t: blur mismatch: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
              $realtime, want.red, want.green, want.blue, want.frame_end,
              got.red, got.green, got.blue, got.frame_end));
        end
      end

      // any register write restarts the frame
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAME_WIDTH) width_reg = cfg_data_i[FW_W-1:0];
        else                              height_reg = cfg_data_i[FH_W-1:0];
        restart_frame();
      end

      if (pix_i.valid && pix_i.ready)
        blur_beat(pix_i.req_type, {pix_i.red_in, pix_i.green_in, pix_i.blue_in});
    end
    fail_o    <= err_cnt;
    pending_o <= blurred_q.size();
  end

endmodule

/* sim/box_blur_3x3_rgb_test.sv */
// Testbench top for the 3x3 RGB box blur: clock, reset, stimulus, back-pressure, verdict.
// Depends on bb_pkg, bb_if, the block itself and box_blur_checker.
`timescale 1ns / 1ps

module box_blur_3x3_rgb_test;
  import bb_pkg::*;

  localparam int unsigned MAX_W      = 1024;
  localparam int          HOLD_SPAN  = 400;
  localparam int          RAND_BEATS = 520;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bb_pix_in_if  pix_in ();
  bb_pix_out_if pix_out ();

  int          fail_cnt, pending_cnt;
  int unsigned idle_pct, stall_pct;
  logic        hold_kick;
  int          hold_left;

  // Geometry as last written, raw and as the block sees it
  int unsigned width_raw  = RESET_FRAME_WIDTH;
  int unsigned height_raw = RESET_FRAME_HEIGHT;
  int unsigned frame_w, frame_h;

  // Directed 3x3 frame: extremes and values that land on rounding ties
  pix_t corner_mix [9] = '{24'hFFFFFF, 24'h000000, 24'hFF00FF,
                           24'h010203, 24'h7F807F, 24'hFEFDFC,
                           24'h00FF00, 24'h808080, 24'hFFFFFF};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  box_blur_3x3_rgb i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_in),
    .pix_o      (pix_out)
  );

  box_blur_checker i_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_in),
    .pix_o      (pix_out),
    .fail_o     (fail_cnt),
    .pending_o  (pending_cnt)
  );

  // Receiver: random stalls, plus a long hold-off when kicked
  always @(posedge clk_i) begin
    if (hold_kick && hold_left == 0) hold_left <= HOLD_SPAN;
    else if (hold_left != 0)         hold_left <= hold_left - 1;
    pix_out.ready <= rst_ni && !hold_kick && hold_left <= 1 &&
                     ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  task automatic set_phase(input int p);
    case (p % 4)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 53; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 53; end
      default: begin idle_pct = 12; stall_pct = 12; end
    endcase
  endtask

  // Offer one beat, with random idle cycles first; returns at the accepting edge
  task automatic send_beat(input logic kind, input pix_t colour);
    while ($urandom_range(99) < idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid    <= 1'b1;
    pix_in.req_type <= kind;
    pix_in.red_in   <= colour[2*CH_W +: CH_W];
    pix_in.green_in <= colour[CH_W +: CH_W];
    pix_in.blue_in  <= colour[0 +: CH_W];
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  // Stop offering, wait for every expected beat, then let in-flight work finish
  task automatic settle();
    pix_in.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Register writes back to back; write enable drops once after the last
  task automatic set_regs(input bit do_w, input int unsigned w_data,
                          input bit do_h, input int unsigned h_data);
    if (do_w) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_FRAME_WIDTH;
      cfg_data_i <= CFG_DATA_W'(w_data);
      @(posedge clk_i);
      width_raw = w_data & 32'h7FF;
    end
    if (do_h) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_FRAME_HEIGHT;
      cfg_data_i <= CFG_DATA_W'(h_data);
      @(posedge clk_i);
      height_raw = h_data & 32'h1FFF;
    end
    cfg_we_i <= 1'b0;
    frame_w = (width_raw == 0) ? 1 : ((width_raw > MAX_W) ? MAX_W : width_raw);
    frame_h = (height_raw == 0) ? 1 : height_raw;
  endtask

  // Whole frame plus the drain tail; noisy frames add swallowed flushes and
  // pixels past the frame that stand in for flushes
  task automatic run_frame(input bit noisy);
    for (int k = 0; k < frame_w * frame_h; k++) begin
      if (noisy && $urandom_range(15) == 0)
        send_beat(REQ_FLUSH, {pick_channel(), pick_channel(), pick_channel()});
      send_beat(REQ_PIXEL, {pick_channel(), pick_channel(), pick_channel()});
    end
    for (int k = 0; k <= frame_w; k++)
      send_beat((noisy && $urandom_range(3) == 0) ? REQ_PIXEL : REQ_FLUSH,
                {pick_channel(), pick_channel(), pick_channel()});
  endtask

  task automatic kick_hold();
    hold_kick <= 1'b1;
    @(posedge clk_i);
    hold_kick <= 1'b0;
  endtask

  initial begin
    int unsigned fed;
    int          frame_no;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_FRAME_WIDTH;
    cfg_data_i      = '0;
    pix_in.valid    = 1'b0;
    pix_in.req_type = REQ_PIXEL;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_out.ready   = 1'b0;
    hold_kick       = 1'b0;
    hold_left       = 0;
    set_phase(0);
    frame_w = MAX_W;
    frame_h = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: flush into an empty frame at reset geometry is swallowed
    send_beat(REQ_FLUSH, '1);
    settle();

    // Directed 3x3 frame with a mid-frame flush and a pixel past the end
    set_regs(1'b1, 3, 1'b1, 3);
    for (int k = 0; k < 9; k++) begin
      if (k == 4) send_beat(REQ_FLUSH, '0);
      send_beat(REQ_PIXEL, corner_mix[k]);
    end
    send_beat(REQ_PIXEL, 24'hFFFFFF);
    repeat (3) send_beat(REQ_FLUSH, '0);
    settle();

    // Short frame: all results come out during the drain, then a stray flush
    set_regs(1'b1, 2, 1'b1, 1);
    send_beat(REQ_PIXEL, 24'h000000);
    send_beat(REQ_PIXEL, 24'hFFFFFF);
    repeat (4) send_beat(REQ_FLUSH, '1);
    settle();

    // Back-pressure: output held off while the sender keeps offering
    set_regs(1'b1, 16, 1'b1, 8);
    kick_hold();
    run_frame(1'b0);
    settle();

    // Odd geometry: width bits above the register, zero sizes, a tall single column
    set_phase(1);
    set_regs(1'b1, 13'h1805, 1'b1, 0);
    run_frame(1'b1);
    settle();
    set_phase(2);
    set_regs(1'b1, 24, 1'b1, 2);
    run_frame(1'b0);
    settle();
    set_phase(3);
    set_regs(1'b1, 1, 1'b1, 40);
    run_frame(1'b1);
    settle();
    set_phase(0);
    set_regs(1'b1, 0, 1'b1, 1);
    run_frame(1'b1);
    run_frame(1'b0);
    settle();

    // Random frames, mostly small, geometry changed between frames
    fed      = 0;
    frame_no = 0;
    while (fed < RAND_BEATS) begin
      set_phase(frame_no);
      case ($urandom_range(3))
        0: set_regs(1'b1, ($urandom_range(4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8),
                    1'b0, 0);
        1: set_regs(1'b0, 0, 1'b1, $urandom_range(0, 6));
        default: set_regs(1'b1, ($urandom_range(4) == 0) ? $urandom_range(9, 40)
                                                          : $urandom_range(0, 8),
                          1'b1, $urandom_range(0, 6));
      endcase
      if ($urandom_range(5) == 0) kick_hold();
      run_frame(1'b1);
      fed += frame_w * frame_h + frame_w + 1;
      // sometimes a second frame on the same geometry without a restart
      if ($urandom_range(3) == 0) begin
        run_frame(1'b0);
        fed += frame_w * frame_h + frame_w + 1;
      end
      settle();
      frame_no++;
    end

    if (fail_cnt == 0) $display("CHECK OK");
    else               $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
design/bb_pkg.sv
design/bb_if.sv
design/bb_ram.sv
design/box_blur_3x3_rgb.sv
design/bb_checker.sv
sim/box_blur_checker.sv
sim/box_blur_3x3_rgb_test.sv
